### hw/rtl/tsct_pkg.sv
// ----------------------------------------------------------------------------
// Taylor sine/cosine/tangent package
// Shared widths, constants, operation codes and pipeline record types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsct_pkg;

  localparam int OP_W  = 2;
  localparam int ANG_W = 32;
  localparam int VAL_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_SIN = 2'd0,
    OP_COS = 2'd1,
    OP_TAN = 2'd2
  } op_e;

  // Pi and pi/2 in Q.56, rounded to nearest.
  localparam logic [63:0] PI_Q56      = 64'h0324_3F6A_8885_A309;
  localparam logic [63:0] HALF_PI_Q56 = 64'h0192_1FB5_4442_D184;

  // The reduction quotient never exceeds 15 for a Q6.26 angle.
  localparam int RED_STEPS = 4;
  localparam int DIVD_W    = 62;
  localparam int MAG_W     = 31;
  localparam int X2_W      = 32;
  localparam int SUM_W     = 32;
  localparam int NUM_W     = 56;
  localparam int QUO_W     = 33;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic vld;
    op_e  op;
  } ctl_t;

  typedef struct packed {
    logic              pos;
    logic              odd;
    logic [DIVD_W-1:0] rem;
  } red_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] term;
    logic [X2_W-1:0]  x2;
    logic [SUM_W-1:0] sum;
  } ser_t;

  typedef struct packed {
    logic [MAG_W-1:0] cmag;
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [VAL_W-1:0] trig;
    logic             sneg;
    logic             rneg;
    logic             zero;
    logic             big;
  } side_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             sat;
  } res_t;

endpackage

### hw/rtl/tsct_if.sv
// ----------------------------------------------------------------------------
// Taylor sine/cosine/tangent channel interfaces
// Valid/ready channels for the angle requests and the function results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsct_in_if;
  logic                             valid;
  logic                             ready;
  logic        [tsct_pkg::OP_W-1:0]  opcode;
  logic signed [tsct_pkg::ANG_W-1:0] angle;

  modport source (output valid, output opcode, output angle, input ready);
  modport sink   (input valid, input opcode, input angle, output ready);
endinterface

interface tsct_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tsct_pkg::VAL_W-1:0] value;
  logic                             saturated;

  modport source (output valid, output value, output saturated, input ready);
  modport sink   (input valid, input value, input saturated, output ready);
endinterface

### hw/rtl/taylor_sine_cosine_tangent.sv
// ----------------------------------------------------------------------------
// Taylor sine/cosine/tangent unit
// Fixed-point sine, cosine and tangent from a truncated Maclaurin series,
// built as a chain of cells, each taking one step per cycle while not frozen.
//
//   Channel  Dir  Fields                               Role
//   in_i     in   opcode[1:0], angle[31:0] Q6.26       request transaction
//   out_o    out  value[31:0] Q8.24, saturated         result transaction
//
// One transaction is accepted per cycle while the skid register is free;
// each yields exactly one result. The depth of the chain grows with the
// series term cells and the tangent quotient bits.
// Reset clears the control and side records along the chain and the valid
// bits of the output buffer; the datapath registers carry no reset.
// A stalled result holds in the output register and one more in a skid
// register; the chain freezes only once the skid register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module taylor_sine_cosine_tangent #(
  parameter int SERIES_TERMS = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsct_in_if.sink           in_i,
  tsct_out_if.source        out_o
);

  localparam int TERM_CELLS = SERIES_TERMS - 1;
  localparam int RED_N      = tsct_pkg::RED_STEPS;
  localparam int DIV_CELLS  = tsct_pkg::QUO_W;
  // Control travels beside the data from the input register to the end of
  // the series: input stage, reduction, finish, square, three per term.
  localparam int CTL_DEPTH  = 1 + RED_N + 1 + 1 + 3 * TERM_CELLS;
  localparam int MW         = tsct_pkg::MAG_W;
  localparam int SW         = tsct_pkg::SUM_W;
  localparam int NW         = tsct_pkg::NUM_W;
  localparam int VW         = tsct_pkg::VAL_W;
  localparam int QW         = tsct_pkg::QUO_W;

  localparam logic signed [63:0] HALF_S = signed'(tsct_pkg::HALF_PI_Q56);

  // The whole chain moves together whenever the skid register is free.
  logic en;
  logic skid_vld_q;

  assign en         = !skid_vld_q;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // Control line
  // --------------------------------------------------------------------------
  tsct_pkg::ctl_t ctl_q [CTL_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CTL_DEPTH; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en) begin
      ctl_q[0].vld <= in_i.valid;
      ctl_q[0].op  <= tsct_pkg::op_e'(in_i.opcode);
      for (int k = 1; k < CTL_DEPTH; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input stage. Lane 0 carries the sine angle and lane 1 the cosine angle,
  // which is pi/2 minus the input. Each lane picks the dividend for its
  // reduction by pi according to which side of minus pi/2 it lies on.
  // --------------------------------------------------------------------------
  logic signed [63:0] x_lane [2];
  logic               pos_lane [2];
  logic [63:0]        divd_lane [2];
  tsct_pkg::red_t     red_s [2][RED_N+1];

  assign x_lane[0] = {{2{in_i.angle[31]}}, in_i.angle, 30'd0};
  assign x_lane[1] = HALF_S - x_lane[0];

  for (genvar l = 0; l < 2; l++) begin : g_lane_in
    assign pos_lane[l]  = x_lane[l] > -HALF_S;
    assign divd_lane[l] = pos_lane[l] ? 64'(x_lane[l] + HALF_S) : 64'(HALF_S - x_lane[l]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        red_s[l][0].pos <= pos_lane[l];
        red_s[l][0].odd <= 1'b0;
        red_s[l][0].rem <= divd_lane[l][tsct_pkg::DIVD_W-1:0];
      end
    end

    // Quotient bits from the most significant down.
    for (genvar j = 0; j < RED_N; j++) begin : g_red
      tsct_red_cell #(
        .STEP_BIT (RED_N - 1 - j)
      ) u_red (
        .clk_i (clk_i),
        .en_i  (en),
        .red_i (red_s[l][j]),
        .red_o (red_s[l][j+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Finish and square stages. The reduced angle is plus or minus the
  // remainder less pi/2; an odd quotient flips it once more. The series
  // then works on the magnitude in Q.30 and its square.
  // --------------------------------------------------------------------------
  logic              f_neg_q [2];
  logic [MW-1:0]     f_m_q [2];
  tsct_pkg::ser_t    ser_s [2][TERM_CELLS+1];

  for (genvar l = 0; l < 2; l++) begin : g_lane_ser
    logic [63:0] rem64;
    logic [63:0] d_up;
    logic [63:0] d_dn;
    logic        flip;
    logic [63:0] r_sel;
    logic [63:0] r_mag;
    logic [61:0] sq;

    assign rem64 = 64'(red_s[l][RED_N].rem);
    assign d_up  = rem64 - tsct_pkg::HALF_PI_Q56;
    assign d_dn  = tsct_pkg::HALF_PI_Q56 - rem64;
    assign flip  = red_s[l][RED_N].pos ^ red_s[l][RED_N].odd;
    assign r_sel = flip ? d_up : d_dn;
    assign r_mag = r_sel[63] ? (flip ? d_dn : d_up) : r_sel;
    assign sq    = 62'(f_m_q[l]) * 62'(f_m_q[l]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        f_neg_q[l]       <= r_sel[63];
        f_m_q[l]         <= r_mag[56:26];
        ser_s[l][0].neg  <= f_neg_q[l];
        ser_s[l][0].term <= f_m_q[l];
        ser_s[l][0].x2   <= sq[61:30];
        ser_s[l][0].sum  <= SW'(f_m_q[l]);
      end
    end

    for (genvar i = 0; i < TERM_CELLS; i++) begin : g_term
      tsct_term_cell #(
        .TERM_IDX (i + 1)
      ) u_term (
        .clk_i (clk_i),
        .en_i  (en),
        .ser_i (ser_s[l][i]),
        .ser_o (ser_s[l][i+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // End-of-series stage. Sine and cosine are rounded to Q8.24 here. For the
  // tangent the magnitudes are set up for the divider, and a quotient that
  // would reach 2^33 (which always overflows) is caught by a narrow compare.
  // --------------------------------------------------------------------------
  tsct_pkg::ser_t  s_end, c_end, t_sel;
  tsct_pkg::ctl_t  ctl_e;
  logic [SW-1:0]   rnd_e;
  logic [VW-1:0]   q24_e;
  logic            sneg_e;
  logic            cneg_e;
  tsct_pkg::side_t side_d;
  tsct_pkg::div_t  div_d;
  tsct_pkg::side_t side_q [DIV_CELLS+1];
  tsct_pkg::div_t  div_s [DIV_CELLS+1];

  always_comb begin
    s_end  = ser_s[0][TERM_CELLS];
    c_end  = ser_s[1][TERM_CELLS];
    ctl_e  = ctl_q[CTL_DEPTH-1];
    t_sel  = (ctl_e.op == tsct_pkg::OP_COS) ? c_end : s_end;
    rnd_e  = t_sel.sum + SW'(32);
    q24_e  = VW'(rnd_e[SW-1:6]);
    sneg_e = s_end.neg && (s_end.sum != '0);
    cneg_e = c_end.neg && (c_end.sum != '0);

    side_d.ctl  = ctl_e;
    side_d.trig = t_sel.neg ? VW'(-q24_e) : q24_e;
    side_d.sneg = sneg_e;
    side_d.rneg = sneg_e ^ cneg_e;
    side_d.zero = (c_end.sum == '0);
    side_d.big  = 40'(s_end.sum) >= {c_end.sum, 8'd0};

    div_d.cmag = c_end.sum[MW-1:0];
    div_d.rem  = {s_end.sum[MW-1:0], 25'd0};
    div_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_CELLS; k++) begin
        side_q[k] <= '0;
      end
    end else if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k <= DIV_CELLS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_s[0] <= div_d;
    end
  end

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    tsct_div_cell #(
      .QUO_BIT (DIV_CELLS - 1 - j)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (div_s[j]),
      .div_o (div_s[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Result selection. The tangent quotient carries one extra bit so that it
  // can be rounded half up, then it is checked against the limits of Q8.24.
  // --------------------------------------------------------------------------
  tsct_pkg::side_t side_z;
  logic [QW:0]     qf1_z;
  logic [QW-1:0]   q_z;
  logic [QW-1:0]   qn_z;
  tsct_pkg::res_t  res_z;

  always_comb begin
    side_z = side_q[DIV_CELLS];
    qf1_z  = {1'b0, div_s[DIV_CELLS].quo} + (QW+1)'(1);
    q_z    = qf1_z[QW:1];
    qn_z   = -q_z;
    res_z  = '0;
    case (side_z.ctl.op)
      tsct_pkg::OP_SIN, tsct_pkg::OP_COS: begin
        res_z.value = side_z.trig;
      end
      tsct_pkg::OP_TAN: begin
        if (side_z.zero) begin
          res_z.sat   = 1'b1;
          res_z.value = side_z.sneg ? tsct_pkg::VAL_MIN : tsct_pkg::VAL_MAX;
        end else if (side_z.big) begin
          res_z.sat   = 1'b1;
          res_z.value = side_z.rneg ? tsct_pkg::VAL_MIN : tsct_pkg::VAL_MAX;
        end else if (side_z.rneg) begin
          if (q_z > QW'(tsct_pkg::VAL_MIN)) begin
            res_z.sat   = 1'b1;
            res_z.value = tsct_pkg::VAL_MIN;
          end else begin
            res_z.value = qn_z[VW-1:0];
          end
        end else begin
          if (q_z > QW'(tsct_pkg::VAL_MAX)) begin
            res_z.sat   = 1'b1;
            res_z.value = tsct_pkg::VAL_MAX;
          end else begin
            res_z.value = q_z[VW-1:0];
          end
        end
      end
      default: begin
        res_z = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register with skid register. A result that meets a stalled output
  // parks in the skid register, which then freezes the chain.
  // --------------------------------------------------------------------------
  logic           out_vld_q;
  tsct_pkg::res_t out_res_q;
  tsct_pkg::res_t skid_res_q;
  logic           out_stall;
  logic           z_take;

  assign out_stall = out_vld_q && !out_o.ready;
  assign z_take    = en && side_z.ctl.vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_stall) begin
      if (z_take) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= z_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_stall) begin
      if (z_take) begin
        skid_res_q <= res_z;
      end
    end else if (skid_vld_q) begin
      out_res_q <= skid_res_q;
    end else if (z_take) begin
      out_res_q <= res_z;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.value     = out_res_q.value;
  assign out_o.saturated = out_res_q.sat;

`ifndef NO_ASSERTIONS
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_o.ready))
    else $error("skid register filled without a stalled output");

  a_zero_is_big : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_q[0].ctl.vld && side_q[0].zero) |-> side_q[0].big)
    else $error("zero cosine not flagged as an overflowing quotient");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_q[DIV_CELLS].ctl.vld && !side_q[DIV_CELLS].big)
      |-> (div_s[DIV_CELLS].rem < NW'(div_s[DIV_CELLS].cmag)))
    else $error("tangent divider left a remainder not below the cosine");
`endif

endmodule

### hw/rtl/tsct_red_cell.sv
// ----------------------------------------------------------------------------
// Reduction cell
// One restoring step of the division of the shifted angle by pi.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsct_red_cell #(
  parameter int STEP_BIT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  tsct_pkg::red_t  red_i,
  output tsct_pkg::red_t  red_o
);

  localparam int W = tsct_pkg::DIVD_W;
  localparam logic [W-1:0] STEP = W'(tsct_pkg::PI_Q56 << STEP_BIT);

  tsct_pkg::red_t red_d, red_q;

  always_comb begin
    red_d = red_i;
    if (red_i.rem >= STEP) begin
      red_d.rem = red_i.rem - STEP;
      // Only the lowest quotient bit decides the sign flip.
      if (STEP_BIT == 0) begin
        red_d.odd = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q <= red_d;
    end
  end

  assign red_o = red_q;

endmodule

### hw/rtl/tsct_term_cell.sv
// ----------------------------------------------------------------------------
// Series term cell
// Forms the next Maclaurin term and folds it into the running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsct_term_cell #(
  parameter int TERM_IDX = 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  tsct_pkg::ser_t  ser_i,
  output tsct_pkg::ser_t  ser_o
);

  localparam int D     = 2 * TERM_IDX * (2 * TERM_IDX + 1);
  localparam int DW    = $clog2(D + 1);
  localparam int QDW   = 32 + DW;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / D);
  localparam bit SUBTRACT = (TERM_IDX % 2) == 1;

  localparam int MW = tsct_pkg::MAG_W;
  localparam int XW = tsct_pkg::X2_W;
  localparam int SW = tsct_pkg::SUM_W;

  // Stage A: term times x^2.
  logic [62:0]   prod_a;
  logic          a_neg_q;
  logic [31:0]   a_p_q;
  logic [XW-1:0] a_x2_q;
  logic [SW-1:0] a_sum_q;

  // Stage B: quotient estimate by reciprocal.
  logic [63:0]   prod_b;
  logic          b_neg_q;
  logic [31:0]   b_p_q;
  logic [31:0]   b_qh_q;
  logic [XW-1:0] b_x2_q;
  logic [SW-1:0] b_sum_q;

  // Stage C: one correction step, then accumulate.
  logic [QDW-1:0] qd_c;
  logic [QDW-1:0] rr_c;
  logic [31:0]    qt_c;
  logic [MW-1:0]  term_c;
  tsct_pkg::ser_t ser_d, ser_q;

  assign prod_a = 63'(ser_i.term) * 63'(ser_i.x2);
  assign prod_b = 64'(a_p_q) * 64'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_neg_q <= ser_i.neg;
      a_p_q   <= prod_a[61:30];
      a_x2_q  <= ser_i.x2;
      a_sum_q <= ser_i.sum;
      b_neg_q <= a_neg_q;
      b_p_q   <= a_p_q;
      b_qh_q  <= prod_b[63:32];
      b_x2_q  <= a_x2_q;
      b_sum_q <= a_sum_q;
      ser_q   <= ser_d;
    end
  end

  always_comb begin
    qd_c   = QDW'(b_qh_q) * QDW'(D);
    rr_c   = QDW'(b_p_q) - qd_c;
    qt_c   = b_qh_q + ((rr_c >= QDW'(D)) ? 32'd1 : 32'd0);
    term_c = qt_c[MW-1:0];
    ser_d.neg  = b_neg_q;
    ser_d.term = term_c;
    ser_d.x2   = b_x2_q;
    if (SUBTRACT) begin
      ser_d.sum = b_sum_q - SW'(term_c);
    end else begin
      ser_d.sum = b_sum_q + SW'(term_c);
    end
  end

  assign ser_o = ser_q;

endmodule

### hw/rtl/tsct_div_cell.sv
// ----------------------------------------------------------------------------
// Tangent divider cell
// One restoring step of the sine over cosine division, one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsct_div_cell #(
  parameter int QUO_BIT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  tsct_pkg::div_t  div_i,
  output tsct_pkg::div_t  div_o
);

  localparam int NW = tsct_pkg::NUM_W;

  logic [63:0]    trial;
  tsct_pkg::div_t div_d, div_q;

  always_comb begin
    trial = 64'(div_i.cmag) << QUO_BIT;
    div_d = div_i;
    if (64'(div_i.rem) >= trial) begin
      div_d.rem          = div_i.rem - NW'(trial);
      div_d.quo[QUO_BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

### tb/taylor_sine_cosine_tangent_test.sv
// ----------------------------------------------------------------------------
// Taylor sine/cosine/tangent testbench
// Drives angle requests with random idling on both channels and checks every
// result against a bit-exact fixed-point prediction of the series unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected results in order, with a running count of mismatches.
class trig_scoreboard;
  logic [31:0] want_value[$];
  logic        want_sat[$];
  int          errors;
  int          checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  // Sine of a Q.56 angle as signed Q.30, with reduction by multiples of pi.
  static function longint sine_q30(longint x);
    longint      k;
    longint      r;
    longint      total;
    logic [63:0] kmag;
    logic [63:0] mag;
    logic [63:0] x2;
    logic [63:0] term;
    logic        neg;
    logic [63:0] pi_q;
    logic [63:0] hpi_q;
    pi_q  = tsct_pkg::PI_Q56;
    hpi_q = tsct_pkg::HALF_PI_Q56;
    if (x > -longint'(hpi_q))
      k = longint'(unsigned'(x + longint'(hpi_q)) / pi_q);
    else
      k = -longint'(unsigned'(longint'(hpi_q) - x) / pi_q);
    r    = x - k * longint'(pi_q);
    kmag = (k < 0) ? -k : k;
    if (kmag[0]) r = -r;
    neg   = (r < 0);
    mag   = (neg ? -r : r) >> 26;
    x2    = (mag * mag) >> 30;
    total = mag;
    term  = mag;
    for (int i = 1; i < 9; i++) begin
      term = ((term * x2) >> 30) / ((2 * i) * (2 * i + 1));
      if (i % 2) total -= longint'(term);
      else total += longint'(term);
    end
    return neg ? -total : total;
  endfunction

  static function longint round_q24(longint v);
    logic [63:0] mag;
    longint      q;
    mag = (v < 0) ? -v : v;
    q   = (mag + 32) >> 6;
    return (v < 0) ? -q : q;
  endfunction

  // Computes the result of one accepted request and queues it.
  function void note_request(logic [1:0] op, logic [31:0] angle);
    longint      x;
    longint      s;
    longint      c;
    longint      v;
    logic        sat;
    logic [63:0] smag;
    logic [63:0] cmag;
    logic [63:0] q;
    x   = longint'(signed'(angle)) * (longint'(1) << 30);
    v   = 0;
    sat = 1'b0;
    case (op)
      tsct_pkg::OP_SIN: v = round_q24(sine_q30(x));
      tsct_pkg::OP_COS: v = round_q24(sine_q30(longint'(tsct_pkg::HALF_PI_Q56) - x));
      tsct_pkg::OP_TAN: begin
        s    = sine_q30(x);
        c    = sine_q30(longint'(tsct_pkg::HALF_PI_Q56) - x);
        smag = (s < 0) ? -s : s;
        cmag = (c < 0) ? -c : c;
        if (cmag == 0) begin
          sat = 1'b1;
          v   = (s < 0) ? -longint'(32'h8000_0000) : longint'(32'h7FFF_FFFF);
        end else begin
          q = (((smag << 25) / cmag) + 1) >> 1;
          if ((s < 0) != (c < 0)) begin
            if (q > 64'h8000_0000) begin
              q   = 64'h8000_0000;
              sat = 1'b1;
            end
            v = -longint'(q);
          end else begin
            if (q > 64'h7FFF_FFFF) begin
              q   = 64'h7FFF_FFFF;
              sat = 1'b1;
            end
            v = longint'(q);
          end
        end
      end
      default: v = 0;
    endcase
    want_value.push_back(v[31:0]);
    want_sat.push_back(sat);
  endfunction

  function void check_result(logic [31:0] value, logic sat);
    logic [31:0] ev;
    logic        es;
    if (want_value.size() == 0) begin
      $display("%0t: unexpected result value=%h saturated=%b", $time, value, sat);
      errors++;
      return;
    end
    ev = want_value.pop_front();
    es = want_sat.pop_front();
    checked++;
    if (value !== ev) begin
      $display("%0t: value expected %h actual %h", $time, ev, value);
      errors++;
    end
    if (sat !== es) begin
      $display("%0t: saturated expected %b actual %b", $time, es, sat);
      errors++;
    end
  endfunction
endclass

module taylor_sine_cosine_tangent_test;

  localparam int LATENCY   = 66;
  localparam int MAX_CYCLE = 400000;

  logic clk_i;
  logic rst_ni;

  tsct_in_if  req_ch ();
  tsct_out_if res_ch ();

  taylor_sine_cosine_tangent u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (res_ch.source)
  );

  trig_scoreboard trig_sb;

  // Random idling is switched off for the closing stretch of the run.
  bit     idle_on;
  longint cycle_count;
  int     sent;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Cycle counter with a hard stop well beyond the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Results are sampled at the edge; the ready for the next cycle is set in
  // the same step with one nonblocking assignment, in bursts of stall.
  initial begin
    int stall;
    stall = 0;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready)
        trig_sb.check_result(res_ch.value, res_ch.saturated);
      if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 12);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Sends one request transaction and waits for it to be accepted. An idle
  // burst, when drawn, is spent before the request is raised.
  task automatic send_request(logic [1:0] op, logic [31:0] angle);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.angle  <= angle;
    do @(posedge clk_i); while (!req_ch.ready);
    trig_sb.note_request(op, angle);
    sent++;
  endtask

  task automatic go_quiet();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (trig_sb.want_value.size() != 0) @(posedge clk_i);
  endtask

  // Angles near multiples of pi/4 hit the reduction edges and the poles.
  function automatic logic [31:0] pick_angle();
    logic [31:0] a;
    longint      base;
    case ($urandom_range(0, 3))
      0: a = $urandom();
      1: a = $urandom_range(0, 32'h0C00_0000) - 32'h0600_0000;
      default: begin
        base = longint'($urandom_range(0, 80)) - 40;
        a = 32'(base * 64'h0648_7ED5 / 2 + longint'($urandom_range(0, 64)) - 32);
      end
    endcase
    return a;
  endfunction

  initial begin
    logic [31:0] edge_angles[$];
    logic [1:0]  op;
    trig_sb      = new();
    idle_on      = 1'b1;
    cycle_count  = 0;
    sent         = 0;
    rst_ni       = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.opcode = tsct_pkg::OP_SIN;
    req_ch.angle  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, zero, pi/2 (cosine near zero) and its
    // negative, for every operation including the unused opcode.
    edge_angles = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0648_7ED5,
                    32'hF9B7_812B, 32'h0000_0001, 32'hFFFF_FFFF};
    foreach (edge_angles[i])
      for (int o = 0; o < 4; o++) send_request(2'(o), edge_angles[i]);

    // Hold off until everything sent has come back.
    go_quiet();

    for (int n = 0; n < 1050; n++) begin
      if (n == 900) idle_on = 1'b0;
      op = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      send_request(op, pick_angle());
    end
    req_ch.valid <= 1'b0;

    while (trig_sb.want_value.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d requests over sine, cosine, tangent and the unused code;",
             sent);
    $display("checked %0d results, including pole and range-edge angles.",
             trig_sb.checked);
    if (trig_sb.errors == 0 && trig_sb.want_value.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tsct_pkg.sv
hw/rtl/tsct_if.sv
hw/rtl/tsct_red_cell.sv
hw/rtl/tsct_term_cell.sv
hw/rtl/tsct_div_cell.sv
hw/rtl/taylor_sine_cosine_tangent.sv
tb/taylor_sine_cosine_tangent_test.sv
